@@ rtl/assert_macros.svh @@
// Assertion macros used by the top level of the window tracker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define AWT_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising clock edge outside reset.
`define AWT_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/awt_pkg.sv @@
// Types and constants shared by the window tracker modules.
package awt_pkg;

  localparam int OFF_W   = 32;
  localparam int ELEMS_W = 24;
  localparam int E_W     = 9;
  localparam int W_W     = 7;
  localparam int BASE_W  = 15;
  localparam int SLOT_W  = 16;
  localparam int EW_W    = 15;
  localparam int CFG_W   = 15;
  localparam int IDX_REG_W = 2;

  localparam logic [E_W-1:0] E_MAX      = 9'd256;
  localparam logic [W_W-1:0] MAX_WINDOW = 7'd64;

  typedef enum logic [2:0] {
    KIND_SEND   = 3'd0,
    KIND_RESEND = 3'd1,
    KIND_RETIRE = 3'd2,
    KIND_DUP    = 3'd3,
    KIND_ERROR  = 3'd4
  } kind_e;

  typedef enum logic {
    CMD_START = 1'b0,
    CMD_REPLY = 1'b1
  } cmd_e;

  typedef enum logic [IDX_REG_W-1:0] {
    REG_EPC  = 2'd0,
    REG_WIN  = 2'd1,
    REG_BASE = 2'd2
  } reg_e;

  typedef struct packed {
    cmd_e             op;
    logic [OFF_W-1:0] operand;
  } cmd_t;

  typedef struct packed {
    logic [E_W-1:0]    e;
    logic [W_W-1:0]    w;
    logic [BASE_W-1:0] base;
    logic [EW_W-1:0]   ew;
  } cfg_t;

  typedef struct packed {
    kind_e             kind;
    logic [OFF_W-1:0]  off;
    logic [SLOT_W-1:0] slot;
    logic [E_W-1:0]    valid;
    logic              done;
    logic              last;
  } res_t;

endpackage

@@ rtl/awt_if.sv @@
// Valid/ready channel interfaces for the window tracker input and result words.
interface awt_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [31:0] elem_offset;
  logic [23:0] tensor_elems;

  modport source(output valid, action, elem_offset, tensor_elems, input ready);
  modport sink(input valid, action, elem_offset, tensor_elems, output ready);
endinterface

interface awt_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [31:0] chunk_offset;
  logic [15:0] slot_index;
  logic [8:0]  valid_entries;
  logic        all_done;
  logic        last;

  modport source(output valid, kind, chunk_offset, slot_index, valid_entries, all_done,
                 last, input ready);
  modport sink(input valid, kind, chunk_offset, slot_index, valid_entries, all_done,
               last, output ready);
endinterface

@@ rtl/aggregation_window_tracker.sv @@
// Top level of the worker-side aggregation window tracker.
//
// The tracker takes start and reply words, one at a time, and answers each with result
// words that describe which chunks to send, which slots to retire, and which replies are
// duplicates or errors. Input words land in a two-deep command queue, so a new word is
// taken while the back end is still busy or a result still waits on the output register.
// Steps: a reply makes two passes through a shared bit-serial divider (chunk index,
// then slot index modulo twice the window); the reply that completes a tensor adds a
// third pass for the set-shift update. A start first divides for the chunk count, then
// clears one seen-map entry per cycle for each chunk of the tensor; a second division
// that folds the set shift below twice the window runs at the same time, and the burst
// waits for it. Then follows the first burst (up to the window size), one descriptor
// per cycle while the output register is free.
// The seen-map is a one-bit memory of MAX_CHUNKS entries; only the entries a tensor uses
// are cleared, at its start, so no clearing pass follows reset. Configuration is written
// through cfg_we_i, cfg_idx_i and cfg_data_i, and must only change while no word is at work.
module aggregation_window_tracker #(
  parameter int MAX_CHUNKS = 4096
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  awt_in_if.sink                           in_i,
  awt_out_if.source                        out_o,
  input  logic                             cfg_we_i,
  input  logic [awt_pkg::IDX_REG_W-1:0]    cfg_idx_i,
  input  logic [awt_pkg::CFG_W-1:0]        cfg_data_i
);
  import awt_pkg::*;

  `include "assert_macros.svh"

  logic [E_W-1:0]    epc_q, epc_d;
  logic [W_W-1:0]    win_q, win_d;
  logic [BASE_W-1:0] base_q, base_d;
  logic [EW_W-1:0]   ew_q;
  cfg_t              cfg;
  cmd_t              cmd;
  logic              cmd_valid, cmd_ready;
  res_t              res;
  logic              res_valid;

  // Register writes; an index past the list is ignored.
  always_comb begin
    epc_d  = epc_q;
    win_d  = win_q;
    base_d = base_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_EPC:  epc_d  = cfg_data_i[E_W-1:0];
        REG_WIN:  win_d  = cfg_data_i[W_W-1:0];
        REG_BASE: base_d = cfg_data_i[BASE_W-1:0];
        default:  ;
      endcase
    end
  end

  // Out-of-range settings are clamped: a zero chunk size or window acts as one.
  always_comb begin
    cfg.e    = (epc_q == '0) ? E_W'(1) : ((epc_q > E_MAX) ? E_MAX : epc_q);
    cfg.w    = (win_q == '0) ? W_W'(1) : ((win_q > MAX_WINDOW) ? MAX_WINDOW : win_q);
    cfg.base = base_q;
    cfg.ew   = ew_q;
  end

  // The stride of one window in elements is registered from the clamped settings.
  always_ff @(posedge clk_i) begin
    ew_q <= EW_W'(cfg.e * cfg.w);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      epc_q  <= E_W'(32);
      win_q  <= W_W'(32);
      base_q <= '0;
    end else begin
      epc_q  <= epc_d;
      win_q  <= win_d;
      base_q <= base_d;
    end
  end

  awt_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cmd_o       (cmd),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready)
  );

  awt_back #(
    .MAX_CHUNKS (MAX_CHUNKS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_ready),
    .cfg_i       (cfg),
    .res_o       (res),
    .res_valid_o (res_valid),
    .res_ready_i (out_o.ready)
  );

  assign out_o.valid         = res_valid;
  assign out_o.kind          = res.kind;
  assign out_o.chunk_offset  = res.off;
  assign out_o.slot_index    = res.slot;
  assign out_o.valid_entries = res.valid;
  assign out_o.all_done      = res.done;
  assign out_o.last          = res.last;

  // Error words carry nothing but the last flag.
  `AWT_ASSERT_IMP(a_err_zero, clk_i, rst_ni, res_valid && (res.kind == KIND_ERROR),
    (res.off == '0) && (res.slot == '0) && (res.valid == '0) && !res.done && res.last,
    "error word carries payload")
  // A send descriptor always covers at least one real entry.
  `AWT_ASSERT_IMP(a_send_nonempty, clk_i, rst_ni, res_valid && (res.kind == KIND_SEND),
    (res.valid != '0) && !res.done, "send descriptor without entries")
  // Once the back end takes a command it is busy for at least the next cycle.
  `AWT_ASSERT_NXT(a_cmd_one, clk_i, rst_ni, cmd_valid && cmd_ready, !cmd_ready,
    "back end took two commands in a row")

endmodule

@@ rtl/awt_front.sv @@
// Front end: accepts input words, classifies them into commands and queues them.
module awt_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  awt_in_if.sink        in_i,
  output awt_pkg::cmd_t cmd_o,
  output logic          cmd_valid_o,
  input  logic          cmd_ready_i
);
  import awt_pkg::*;

  cmd_t       fifo_q [2];
  logic       wr_q, wr_d, rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push, pop;
  cmd_t       cmd_new;

  // A start carries the tensor length as its operand, a reply the chunk offset.
  always_comb begin
    cmd_new.op      = in_i.action ? CMD_REPLY : CMD_START;
    cmd_new.operand = in_i.action ? in_i.elem_offset : OFF_W'(in_i.tensor_elems);
  end

  assign in_i.ready  = (cnt_q != 2'd2);
  assign push        = in_i.valid && in_i.ready;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign pop         = cmd_valid_o && cmd_ready_i;
  assign cmd_o       = fifo_q[rd_q];

  always_comb begin
    wr_d  = push ? ~wr_q : wr_q;
    rd_d  = pop ? ~rd_q : rd_q;
    cnt_d = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_q] <= cmd_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

@@ rtl/awt_div.sv @@
// Shared restoring divider: one quotient bit per cycle.
module awt_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [awt_pkg::OFF_W-1:0]  dividend_i,
  input  logic [awt_pkg::E_W-1:0]    divisor_i,
  output logic                       busy_o,
  output logic [awt_pkg::OFF_W-1:0]  quot_o,
  output logic [awt_pkg::E_W-1:0]    rem_o
);
  import awt_pkg::*;

  localparam int CNT_W = $clog2(OFF_W + 1);

  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [OFF_W-1:0] quot_q, quot_d;
  logic [E_W-1:0]   rem_q, rem_d, dvs_q, dvs_d;
  logic [E_W:0]     trial, diff;
  logic             ge;

  always_comb begin
    trial  = {rem_q, quot_q[OFF_W-1]};
    ge     = (trial >= {1'b0, dvs_q});
    diff   = trial - {1'b0, dvs_q};
    cnt_d  = cnt_q;
    quot_d = quot_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i && (cnt_q == '0)) begin
      cnt_d  = CNT_W'(OFF_W);
      quot_d = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (cnt_q != '0) begin
      cnt_d  = cnt_q - 1'b1;
      quot_d = {quot_q[OFF_W-2:0], ge};
      rem_d  = ge ? diff[E_W-1:0] : trial[E_W-1:0];
    end
  end

  assign busy_o = (cnt_q != '0);
  assign quot_o = quot_q;
  assign rem_o  = rem_q;

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

endmodule

@@ rtl/awt_back.sv @@
// Back end: runs start and reply commands against the seen-map and emits results.
module awt_back #(
  parameter int MAX_CHUNKS = 4096
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  awt_pkg::cmd_t cmd_i,
  input  logic          cmd_valid_i,
  output logic          cmd_ready_o,
  input  awt_pkg::cfg_t cfg_i,
  output awt_pkg::res_t res_o,
  output logic          res_valid_o,
  input  logic          res_ready_i
);
  import awt_pkg::*;

  localparam int IDX_W = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
  localparam int CNT_W = $clog2(MAX_CHUNKS + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SDIV  = 3'd1;
  localparam logic [2:0] S_SCLR  = 3'd2;
  localparam logic [2:0] S_BURST = 3'd3;
  localparam logic [2:0] S_RDIV  = 3'd4;
  localparam logic [2:0] S_RMOD  = 3'd5;
  localparam logic [2:0] S_RSH   = 3'd6;

  logic [2:0]         state_q, state_d;
  logic [OFF_W-1:0]   opnd_q, opnd_d;
  logic               busy_q, busy_d;
  logic [CNT_W-1:0]   total_q, total_d, rcnt_q, rcnt_d, cnt_q, cnt_d;
  logic [ELEMS_W-1:0] len_q, len_d;
  logic [W_W-1:0]     shift_q, shift_d, j_q, j_d;
  logic [OFF_W-1:0]   o_q, o_d;
  logic [IDX_W-1:0]   idx_q, idx_d;
  logic               seen_q;
  res_t               res_q, res_d;
  logic               res_valid_q, res_valid_d;

  logic               map_mem [MAX_CHUNKS];
  logic               map_we, map_wdata;
  logic [IDX_W-1:0]   map_waddr;

  logic               div_start, div_busy;
  logic [OFF_W-1:0]   div_dvd, div_quot;
  logic [E_W-1:0]     div_dvs, div_rem;

  logic               out_free;
  logic [OFF_W-1:0]   total_full;
  logic [E_W-1:0]     two_w;
  logic [W_W:0]       jn;
  logic [OFF_W:0]     next_off;
  logic [CNT_W-1:0]   rc1;
  logic [ELEMS_W-1:0] rem_len;

  // Slot of a set index below twice the window.
  function automatic logic [SLOT_W-1:0] slot_map(input logic [W_W:0] i,
                                                 input logic [W_W-1:0] w,
                                                 input logic [BASE_W-1:0] base);
    logic              hi;
    logic [W_W:0]      d;
    logic [BASE_W-1:0] s;
    hi = (i >= {1'b0, w});
    d  = hi ? (i - {1'b0, w}) : i;
    s  = base + BASE_W'(d);
    return {hi, s};
  endfunction

  // Sum of two values below twice the window, folded back below it.
  function automatic logic [W_W:0] wrap2w(input logic [W_W:0] a, input logic [W_W:0] b,
                                          input logic [W_W-1:0] w);
    logic [W_W+1:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, w, 1'b0}) begin
      s = s - {1'b0, w, 1'b0};
    end
    return s[W_W:0];
  endfunction

  awt_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .busy_o     (div_busy),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  assign out_free    = !res_valid_q || res_ready_i;
  assign cmd_ready_o = (state_q == S_IDLE);
  assign two_w       = {1'b0, cfg_i.w, 1'b0};
  assign total_full  = div_quot + OFF_W'(div_rem != '0);
  assign jn          = {1'b0, j_q} + 1'b1;
  assign next_off    = {1'b0, opnd_q} + (OFF_W + 1)'(cfg_i.ew);
  assign rc1         = rcnt_q + 1'b1;

  always_comb begin
    state_d     = state_q;
    opnd_d      = opnd_q;
    busy_d      = busy_q;
    total_d     = total_q;
    rcnt_d      = rcnt_q;
    cnt_d       = cnt_q;
    len_d       = len_q;
    shift_d     = shift_q;
    j_d         = j_q;
    o_d         = o_q;
    idx_d       = idx_q;
    res_d       = res_q;
    res_valid_d = res_valid_q && !res_ready_i;
    map_we      = 1'b0;
    map_wdata   = 1'b0;
    map_waddr   = idx_q;
    div_start   = 1'b0;
    div_dvd     = opnd_q;
    div_dvs     = cfg_i.e;
    rem_len     = '0;

    unique case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          opnd_d    = cmd_i.operand;
          div_start = 1'b1;
          div_dvd   = cmd_i.operand;
          if (cmd_i.op == CMD_START) begin
            busy_d  = 1'b0;
            state_d = S_SDIV;
          end else begin
            state_d = S_RDIV;
          end
        end
      end

      S_SDIV: begin
        if (!div_busy && out_free) begin
          if (total_full > OFF_W'(MAX_CHUNKS)) begin
            res_d       = '{kind: KIND_ERROR, off: '0, slot: '0, valid: '0,
                            done: 1'b0, last: 1'b1};
            res_valid_d = 1'b1;
            state_d     = S_IDLE;
          end else if (total_full == '0) begin
            res_d       = '{kind: KIND_RETIRE, off: '0, slot: '0, valid: '0,
                            done: 1'b1, last: 1'b1};
            res_valid_d = 1'b1;
            len_d       = '0;
            total_d     = '0;
            rcnt_d      = '0;
            state_d     = S_IDLE;
          end else begin
            total_d = total_full[CNT_W-1:0];
            len_d   = opnd_q[ELEMS_W-1:0];
            rcnt_d  = '0;
            busy_d  = 1'b1;
            cnt_d   = '0;
            // The set shift may come from a wider window, so fold it below twice the
            // current window while the map is being cleared.
            div_start = 1'b1;
            div_dvd   = OFF_W'(shift_q);
            div_dvs   = two_w;
            state_d   = S_SCLR;
          end
        end
      end

      S_SCLR: begin
        map_we    = 1'b1;
        map_wdata = 1'b0;
        map_waddr = cnt_q[IDX_W-1:0];
        cnt_d     = cnt_q + 1'b1;
        if (cnt_d == total_q) begin
          j_d     = '0;
          o_d     = '0;
          state_d = S_BURST;
        end
      end

      S_BURST: begin
        if (out_free && !div_busy) begin
          rem_len     = len_q - o_q[ELEMS_W-1:0];
          res_d.kind  = KIND_SEND;
          res_d.off   = o_q;
          res_d.slot  = slot_map(wrap2w({1'b0, j_q}, div_rem[W_W:0], cfg_i.w), cfg_i.w,
                                 cfg_i.base);
          res_d.valid = (rem_len < ELEMS_W'(cfg_i.e)) ? rem_len[E_W-1:0] : cfg_i.e;
          res_d.done  = 1'b0;
          res_d.last  = (OFF_W'(jn) == OFF_W'(total_q)) || (jn == {1'b0, cfg_i.w});
          res_valid_d = 1'b1;
          j_d         = jn[W_W-1:0];
          o_d         = o_q + OFF_W'(cfg_i.e);
          if (res_d.last) begin
            state_d = S_IDLE;
          end
        end
      end

      S_RDIV: begin
        if (!div_busy) begin
          if (!busy_q || (div_quot >= OFF_W'(total_q)) ||
              (div_quot >= OFF_W'(MAX_CHUNKS))) begin
            if (out_free) begin
              res_d       = '{kind: KIND_ERROR, off: '0, slot: '0, valid: '0,
                              done: 1'b0, last: 1'b1};
              res_valid_d = 1'b1;
              state_d     = S_IDLE;
            end
          end else begin
            idx_d     = div_quot[IDX_W-1:0];
            div_start = 1'b1;
            div_dvd   = OFF_W'(div_quot[IDX_W-1:0]) + OFF_W'(shift_q);
            div_dvs   = two_w;
            state_d   = S_RMOD;
          end
        end
      end

      S_RMOD: begin
        if (!div_busy && out_free) begin
          res_valid_d = 1'b1;
          state_d     = S_IDLE;
          if (seen_q) begin
            res_d = '{kind: KIND_DUP, off: opnd_q, slot: '0, valid: '0,
                      done: 1'b0, last: 1'b1};
          end else begin
            map_we     = 1'b1;
            map_wdata  = 1'b1;
            rcnt_d     = rc1;
            res_d.done = (rc1 >= total_q);
            res_d.last = 1'b1;
            if (next_off < (OFF_W + 1)'(len_q)) begin
              rem_len     = len_q - next_off[ELEMS_W-1:0];
              res_d.kind  = KIND_RESEND;
              res_d.off   = next_off[OFF_W-1:0];
              res_d.slot  = slot_map(wrap2w(div_rem[W_W:0], {1'b0, cfg_i.w}, cfg_i.w),
                                     cfg_i.w, cfg_i.base);
              res_d.valid = (rem_len < ELEMS_W'(cfg_i.e)) ? rem_len[E_W-1:0] : cfg_i.e;
            end else begin
              res_d.kind  = KIND_RETIRE;
              res_d.off   = opnd_q;
              res_d.slot  = slot_map(div_rem[W_W:0], cfg_i.w, cfg_i.base);
              res_d.valid = '0;
            end
            if (rc1 >= total_q) begin
              busy_d    = 1'b0;
              div_start = 1'b1;
              div_dvd   = OFF_W'(shift_q) + OFF_W'(total_q);
              div_dvs   = two_w;
              state_d   = S_RSH;
            end
          end
        end
      end

      S_RSH: begin
        if (!div_busy) begin
          shift_d = div_rem[W_W-1:0];
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign res_o       = res_q;
  assign res_valid_o = res_valid_q;

  always_ff @(posedge clk_i) begin
    if (map_we) begin
      map_mem[map_waddr] <= map_wdata;
    end
    seen_q <= map_mem[idx_q];
  end

  always_ff @(posedge clk_i) begin
    opnd_q <= opnd_d;
    len_q  <= len_d;
    j_q    <= j_d;
    o_q    <= o_d;
    idx_q  <= idx_d;
    cnt_q  <= cnt_d;
    res_q  <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      busy_q      <= 1'b0;
      total_q     <= '0;
      rcnt_q      <= '0;
      shift_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      busy_q      <= busy_d;
      total_q     <= total_d;
      rcnt_q      <= rcnt_d;
      shift_q     <= shift_d;
      res_valid_q <= res_valid_d;
    end
  end

endmodule

@@ tb/sv/tb_aggregation_window_tracker.sv @@
// Self-checking testbench for the aggregation window tracker.
module tb_aggregation_window_tracker;
  import awt_pkg::*;

  // One expected result word.
  typedef struct {
    kind_e       kind;
    logic [31:0] off;
    logic [15:0] slot;
    logic [8:0]  valid;
    logic        done;
    logic        last;
  } desc_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [IDX_REG_W-1:0] cfg_idx_i = '0;
  logic [CFG_W-1:0] cfg_data_i = '0;

  awt_in_if  in_ch();
  awt_out_if out_ch();

  aggregation_window_tracker i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_ch.sink),
    .out_o      (out_ch.source),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predictor state: a private copy of the block's configuration and tracking state.
  logic [8:0]  epc_q = 9'd32;
  logic [6:0]  win_q = 7'd32;
  logic [14:0] base_q = '0;
  bit          seen[4096];
  int unsigned rcv_cnt, chunk_cnt, tlen, shift;
  bit          active;

  desc_t expected_q[$];
  int    mismatches;
  int    results_seen;
  int    send_idle_pct, recv_idle_pct;
  bit    hold_recv;
  int    idle_cycles;
  int    starts_sent, replies_sent;

  function automatic int unsigned eff_epc();
    if (epc_q == 0) return 1;
    if (epc_q > 256) return 256;
    return epc_q;
  endfunction

  function automatic int unsigned eff_win();
    if (win_q == 0) return 1;
    if (win_q > 64) return 64;
    return win_q;
  endfunction

  // Pool slot of a chunk: index rotated by the set shift through two sets of slots.
  function automatic logic [15:0] slot_for(logic [31:0] off);
    longint unsigned i;
    int unsigned w;
    w = eff_win();
    i = (longint'(off / eff_epc()) + shift) % (2 * w);
    if (i < w) return {1'b0, 15'(base_q + i)};
    return {1'b1, 15'(base_q + i - w)};
  endfunction

  function automatic logic [8:0] entries_for(logic [31:0] off);
    int unsigned r;
    r = (off < tlen) ? tlen - off : 0;
    return (r < eff_epc()) ? 9'(r) : 9'(eff_epc());
  endfunction

  function automatic void push_result(kind_e k, logic [31:0] o, logic [15:0] s,
                                      logic [8:0] v, logic d);
    desc_t r;
    r.kind = k; r.off = o; r.slot = s; r.valid = v; r.done = d; r.last = 1'b0;
    expected_q.insert(expected_q.size(), r);
  endfunction

  // Works out every result word that one input word causes and queues them.
  function automatic void predict_word(bit is_reply, logic [31:0] off, logic [23:0] elems);
    int unsigned e, w, total, idx, n0;
    longint unsigned nxt;
    bit d;
    e = eff_epc();
    w = eff_win();
    n0 = expected_q.size();
    if (!is_reply) begin
      total = (elems + e - 1) / e;
      active = 0;
      if (total > 4096) begin
        push_result(KIND_ERROR, 0, 0, 0, 0);
      end else if (total == 0) begin
        tlen = 0; chunk_cnt = 0; rcv_cnt = 0;
        foreach (seen[k]) seen[k] = 0;
        push_result(KIND_RETIRE, 0, 0, 0, 1);
      end else begin
        foreach (seen[k]) seen[k] = 0;
        rcv_cnt = 0; chunk_cnt = total; tlen = elems; active = 1;
        for (int j = 0; j < ((total < w) ? total : w); j++)
          push_result(KIND_SEND, j * e, slot_for(j * e), entries_for(j * e), 0);
      end
    end else begin
      idx = off / e;
      if (!active || idx >= chunk_cnt || idx >= 4096) begin
        push_result(KIND_ERROR, 0, 0, 0, 0);
      end else if (seen[idx]) begin
        push_result(KIND_DUP, off, 0, 0, 0);
      end else begin
        seen[idx] = 1;
        rcv_cnt++;
        d = rcv_cnt >= chunk_cnt;
        nxt = longint'(off) + e * w;
        if (nxt < tlen) push_result(KIND_RESEND, nxt[31:0], slot_for(nxt[31:0]),
                                    entries_for(nxt[31:0]), d);
        else push_result(KIND_RETIRE, off, slot_for(off), 0, d);
        if (d) begin
          shift = (shift + chunk_cnt) % (2 * w);
          active = 0;
        end
      end
    end
    if (expected_q.size() > n0) expected_q[$].last = 1'b1;
  endfunction

  // Sends one word; waits out the sender's random gap, then the handshake. The word
  // stays offered until the next call, or until the caller drops valid.
  task automatic send_word(bit is_reply, logic [31:0] off, logic [23:0] elems);
    int unsigned gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.action <= is_reply ? CMD_REPLY : CMD_START;
    in_ch.elem_offset <= off;
    in_ch.tensor_elems <= elems;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    predict_word(is_reply, off, elems);
    if (is_reply) replies_sent++; else starts_sent++;
    @(negedge clk_i);
  endtask

  // Drops valid, waits until every expected word has come, then idles long enough for a
  // last set-shift update to finish.
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk_i);
    repeat (150) @(negedge clk_i);
  endtask

  task automatic write_reg(reg_e idx, int unsigned val);
    drain();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= CFG_W'(val);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_EPC:  epc_q = 9'(val);
      REG_WIN:  win_q = 7'(val);
      default:  base_q = 15'(val);
    endcase
  endtask

  // Result checker: compares each accepted word with the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result word: kind %0d off %0h",
                                       out_ch.kind, out_ch.chunk_offset);
      end else begin
        desc_t x;
        x = expected_q.pop_front();
        if (out_ch.kind !== x.kind || out_ch.chunk_offset !== x.off ||
            out_ch.slot_index !== x.slot || out_ch.valid_entries !== x.valid ||
            out_ch.all_done !== x.done || out_ch.last !== x.last) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("Result mismatch: expected k%0d o%0h s%0h v%0d d%0d l%0d",
                     x.kind, x.off, x.slot, x.valid, x.done, x.last);
            $display("                 actual   k%0d o%0h s%0h v%0d d%0d l%0d",
                     out_ch.kind, out_ch.chunk_offset, out_ch.slot_index,
                     out_ch.valid_entries, out_ch.all_done, out_ch.last);
          end
        end
      end
    end
  end

  // Receiver ready: random stalls, or a long hold-off when asked.
  always @(negedge clk_i) begin
    out_ch.ready <= !hold_recv && ($urandom_range(99) >= recv_idle_pct);
  end

  // Watchdog: counts cycles in which nothing moves on either channel.
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("Watchdog expired with %0d words outstanding", expected_q.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // A full tensor: start, then replies to every chunk in shuffled order with duplicates.
  task automatic run_tensor(int unsigned elems, int dup_pct);
    int unsigned e, total;
    int unsigned order[$];
    e = eff_epc();
    total = (elems + e - 1) / e;
    send_word(0, 0, 24'(elems));
    for (int i = 0; i < total; i++) order.insert(order.size(), i);
    order.shuffle();
    foreach (order[i]) begin
      send_word(1, order[i] * e + $urandom_range(e - 1), 0);
      if ($urandom_range(99) < dup_pct) send_word(1, order[i] * e, 0);
    end
  endtask

  task automatic test_directed();
    send_word(1, 32'd5, 0);                     // reply while idle
    send_word(0, 0, 24'd0);                     // empty tensor
    send_word(0, 0, 24'hFFFFFF);                // too many chunks
    send_word(0, 0, 24'd100);                   // four chunks, padded last one
    send_word(1, 32'd99, 0);
    send_word(1, 32'd96, 0);                    // duplicate
    send_word(1, 32'hFFFFFFFF, 0);              // index out of range
    send_word(1, 32'd0, 0);
    send_word(1, 32'd40, 0);
    send_word(1, 32'd64, 0);                    // completes the tensor
    send_word(0, 0, 24'd50);
    send_word(0, 0, 24'd2000);                  // abandons the previous tensor
    send_word(1, 32'd3, 0);                     // resend of chunk one window ahead
  endtask

  task automatic test_registers();
    write_reg(REG_EPC, 0);   write_reg(REG_WIN, 0);   write_reg(REG_BASE, 32767);
    run_tensor(3, 20);
    write_reg(REG_EPC, 511); write_reg(REG_WIN, 127);
    send_word(0, 0, 24'd300);
    write_reg(REG_EPC, 256); write_reg(REG_WIN, 64);  write_reg(REG_BASE, 32760);
    run_tensor(256 * 70 + 1, 5);
    send_word(0, 0, 24'(256 * 4096));           // exactly the map size
    write_reg(REG_EPC, 1);   write_reg(REG_WIN, 1);   write_reg(REG_BASE, 0);
    send_word(0, 0, 24'd4097);
    run_tensor(6, 30);
  endtask

  task automatic test_random(int unsigned target);
    while (starts_sent + replies_sent < target) begin
      write_reg(REG_EPC, $urandom_range(16, 1));
      write_reg(REG_WIN, $urandom_range(8, 1));
      write_reg(REG_BASE, $urandom_range(32767));
      repeat (3) begin
        if ($urandom_range(9) == 0) send_word(1, $urandom, 0);
        if ($urandom_range(9) == 0) send_word(0, 0, 24'($urandom));
        run_tensor($urandom_range(40 * eff_epc()), 15);
      end
    end
  endtask

  // The block fills its queue while the receiver holds off for a long time.
  task automatic test_backpressure();
    write_reg(REG_EPC, 4); write_reg(REG_WIN, 8);
    fork
      begin
        hold_recv = 1;
        repeat (1500) @(negedge clk_i);
        hold_recv = 0;
      end
      begin
        send_word(0, 0, 24'd64);
        for (int i = 0; i < 6; i++) send_word(1, i * 4, 0);
        in_ch.valid <= 1'b0;
        @(negedge clk_i);
      end
    join
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.action = 1'b0;
    in_ch.elem_offset = '0;
    in_ch.tensor_elems = '0;
    out_ch.ready = 1'b0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    send_idle_pct = 34; recv_idle_pct = 58;
    test_directed();
    test_registers();
    test_random(150);
    send_idle_pct = 58; recv_idle_pct = 34;
    test_backpressure();
    test_random(270);
    send_idle_pct = 0; recv_idle_pct = 0;
    test_random(350);
    drain();
    $display("Covered %0d starts and %0d replies, %0d result words checked.",
             starts_sent, replies_sent, results_seen);
    $display("Register extremes, duplicates, errors and receiver hold-off were exercised.");
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
